// ----- design/ising_weight_quantizer_defines.svh -----
// ----------------------------------------------------------------------------
// Ising weight quantizer assertion macros
// Shared property forms for the checks at the end of the quantizer module.
// ----------------------------------------------------------------------------
`ifndef ISING_WEIGHT_QUANTIZER_DEFINES_SVH
`define ISING_WEIGHT_QUANTIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IWQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("iwq check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IWQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("iwq check failed");

`endif

// ----- design/iwq_pkg.sv -----
// ----------------------------------------------------------------------------
// Ising weight quantizer package
// Codes, widths and types shared by the quantizer and its divider.
// ----------------------------------------------------------------------------
package iwq_pkg;

    localparam int SPIN_COUNT_DEF = 64;
    localparam int WEIGHT_TOP     = 14;
    localparam int DIV_W          = 56;
    localparam int QUOT_W         = 5;
    localparam int PROD_W         = 50;

    localparam logic signed [4:0] W_HI = 5'(WEIGHT_TOP);
    localparam logic signed [4:0] W_LO = -W_HI;

    localparam logic [1:0] NM_LINEAR  = 2'd0;
    localparam logic [1:0] NM_DIRECT  = 2'd1;
    localparam logic [1:0] NM_SIGMOID = 2'd2;

    localparam logic [1:0] MD_CLEAR   = 2'd0;
    localparam logic [1:0] MD_SCAN    = 2'd1;
    localparam logic [1:0] MD_CONVERT = 2'd2;

    localparam logic REG_NORM_MODE = 1'b0;
    localparam logic REG_SCALE     = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ----- design/ising_weight_quantizer.sv -----
// ----------------------------------------------------------------------------
// Ising weight quantizer
// Turns upper-triangle Ising coefficients into pairs of small matrix writes.
// ----------------------------------------------------------------------------
// Clear and scan transactions are taken in the idle state. A convert
// transaction is accepted, multiplied by the scale in ST_MUL, prepared in
// ST_PREP and, in all modes but direct, divided by a shared restoring
// divider that produces one quotient bit per cycle and then hands the quotient
// back; the two result transactions then follow, one per cycle while the
// output is ready. A zero coefficient goes straight to the result transactions,
// and an empty scan range skips the divider in every mode but direct and sigmoid.
// Input ready is high only between conversions.
module ising_weight_quantizer #(
    parameter int SPIN_COUNT = iwq_pkg::SPIN_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_mode,
    input  logic [5:0]         i_row_index,
    input  logic [5:0]         i_col_index,
    input  logic signed [31:0] i_coefficient,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [6:0]         o_out_row,
    output logic [6:0]         o_out_col,
    output logic signed [4:0]  o_weight,
    output logic               o_last
);
    import iwq_pkg::*;
    `include "ising_weight_quantizer_defines.svh"

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_PREP = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_OUT0 = 6'b010000,
        ST_OUT1 = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [1:0]         r_norm_mode;
    logic [15:0]        r_scale;
    logic signed [31:0] r_min;
    logic signed [31:0] r_max;
    logic [5:0]         r_row;
    logic [5:0]         r_col;
    logic               r_diag;
    logic               r_neg;
    logic               r_zero;
    logic [33:0]        r_opnd;
    logic [32:0]        r_span;
    logic [PROD_W-1:0]  r_prod;
    logic [3:0]         r_q;

    logic               in_acc;
    logic               out_acc;
    logic               in_range;
    logic signed [33:0] v_ext;
    logic signed [33:0] min_ext;
    logic signed [33:0] max_ext;
    logic signed [33:0] e_val;
    logic signed [33:0] span_full;
    logic [33:0]        v_abs;
    logic [33:0]        e_abs;
    logic               lin_sel;
    logic [DIV_W-1:0]   p_ext;
    logic [DIV_W-1:0]   div_num;
    logic [DIV_W-1:0]   div_den;
    logic [DIV_W-1:0]   q_direct;
    logic               div_start;
    t_div_stat          div_stat;
    logic [QUOT_W-1:0]  div_quot;
    logic [3:0]         half_m;
    logic [3:0]         rest_m;
    logic [3:0]         sel_m;
    logic [6:0]         row_p1;
    logic [6:0]         col_p1;

    assign o_ready = (r_state == ST_IDLE);
    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign lin_sel = (r_norm_mode != NM_DIRECT) && (r_norm_mode != NM_SIGMOID);

    assign in_range = (int'(i_row_index) < SPIN_COUNT) && (int'(i_col_index) < SPIN_COUNT)
                      && (i_col_index >= i_row_index);

    assign v_ext     = {{2{i_coefficient[31]}}, i_coefficient};
    assign min_ext   = {{2{r_min[31]}}, r_min};
    assign max_ext   = {{2{r_max[31]}}, r_max};
    assign e_val     = {i_coefficient[31], i_coefficient, 1'b0} - min_ext - max_ext;
    assign span_full = max_ext - min_ext;
    assign v_abs     = v_ext[33] ? 34'(-v_ext) : 34'(v_ext);
    assign e_abs     = e_val[33] ? 34'(-e_val) : 34'(e_val);

    assign p_ext = DIV_W'(r_prod);

    always_comb begin
        if (lin_sel) begin
            div_num = (p_ext << 5) - (p_ext << 2) + (DIV_W'(r_span) << 12);
            div_den = DIV_W'(r_span) << 13;
        end else begin
            div_num = (p_ext << 5) - (p_ext << 1) - p_ext + (DIV_W'(1) << 28);
            div_den = (DIV_W'(1) << 29) + (p_ext << 1);
        end
    end

    assign q_direct  = (p_ext + (DIV_W'(1) << 27)) >> 28;
    assign div_start = (r_state == ST_PREP) && (r_norm_mode != NM_DIRECT)
                       && !(lin_sel && r_span == '0);

    iwq_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_mode == MD_CONVERT && in_range) begin
                    n_state = (i_coefficient == '0) ? ST_OUT0 : ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_PREP;
            end
            ST_PREP: begin
                n_state = div_start ? ST_DIV : ST_OUT0;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    n_state = ST_OUT0;
                end
            end
            ST_OUT0: begin
                if (out_acc) begin
                    n_state = ST_OUT1;
                end
            end
            ST_OUT1: begin
                if (out_acc) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_norm_mode <= NM_LINEAR;
            r_scale     <= 16'd4096;
            r_min       <= '0;
            r_max       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_NORM_MODE: r_norm_mode <= i_cfg_wdata[1:0];
                    REG_SCALE:     r_scale     <= i_cfg_wdata;
                    default:       r_scale     <= r_scale;
                endcase
            end
            if (in_acc) begin
                if (i_mode == MD_CLEAR) begin
                    r_min <= '0;
                    r_max <= '0;
                end else if (i_mode == MD_SCAN && in_range) begin
                    if (i_coefficient < r_min) begin
                        r_min <= i_coefficient;
                    end
                    if (i_coefficient > r_max) begin
                        r_max <= i_coefficient;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_row  <= i_row_index;
                r_col  <= i_col_index;
                r_diag <= (i_row_index == i_col_index);
                r_zero <= (i_coefficient == '0);
                r_span <= span_full[32:0];
                r_q    <= '0;
                if (lin_sel) begin
                    r_neg  <= e_val[33];
                    r_opnd <= e_abs;
                end else begin
                    r_neg  <= i_coefficient[31];
                    r_opnd <= v_abs;
                end
            end
            ST_MUL: begin
                r_prod <= PROD_W'(r_scale) * PROD_W'(r_opnd);
            end
            ST_PREP: begin
                if (r_norm_mode == NM_DIRECT) begin
                    r_q <= (q_direct > DIV_W'(WEIGHT_TOP)) ? 4'(WEIGHT_TOP) : q_direct[3:0];
                end else begin
                    r_q <= '0;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    r_q <= (div_quot > QUOT_W'(WEIGHT_TOP)) ? 4'(WEIGHT_TOP) : div_quot[3:0];
                end
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    assign half_m = r_q >> 1;
    assign rest_m = r_q - half_m;
    assign sel_m  = (r_state == ST_OUT0) ? half_m : rest_m;
    assign row_p1 = {1'b0, r_row} + 7'd1;
    assign col_p1 = {1'b0, r_col} + 7'd1;

    assign o_valid  = (r_state == ST_OUT0) || (r_state == ST_OUT1);
    assign o_last   = (r_state == ST_OUT1);
    assign o_weight = r_neg ? -$signed({1'b0, sel_m}) : $signed({1'b0, sel_m});

    always_comb begin
        if (r_diag && !r_zero) begin
            o_out_row = o_last ? row_p1 : 7'd0;
            o_out_col = o_last ? 7'd0 : col_p1;
        end else begin
            o_out_row = o_last ? col_p1 : row_p1;
            o_out_col = o_last ? row_p1 : col_p1;
        end
    end

    `IWQ_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready)
    `IWQ_ASSERT_NXT(a_pair_follows, i_clk, i_rst_n, out_acc && !o_last, o_valid && o_last)
    `IWQ_ASSERT_IMP(a_weight_range, i_clk, i_rst_n, o_valid, (o_weight >= W_LO) && (o_weight <= W_HI))
    `IWQ_ASSERT_IMP(a_minmax_sides, i_clk, i_rst_n, 1'b1, (r_min <= 0) && (r_max >= 0))
    `IWQ_ASSERT_IMP(a_div_in_state, i_clk, i_rst_n, r_state != ST_DIV, !div_stat.busy)

endmodule

// ----- design/iwq_divider.sv -----
// ----------------------------------------------------------------------------
// Ising weight quantizer divider
// Restoring divider that produces a short quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module iwq_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [iwq_pkg::DIV_W-1:0]   i_num,
    input  logic [iwq_pkg::DIV_W-1:0]   i_den,
    output iwq_pkg::t_div_stat          o_stat,
    output logic [iwq_pkg::QUOT_W-1:0]  o_quot
);
    import iwq_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W);

    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_den;
    logic [QUOT_W-1:0] r_quot;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic              fits;

    assign fits = (r_rem >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den << (QUOT_W - 1);
            r_quot <= '0;
            r_cnt  <= CNT_W'(QUOT_W - 1);
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_den;
            end
            r_quot <= {r_quot[QUOT_W-2:0], fits};
            r_den  <= r_den >> 1;
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

// ----- bench/weight_pair_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weight pair checker
// Watches the coefficient and matrix-write channels and the register port.
// It keeps its own copy of the mode registers and the scan range, predicts the
// pair of matrix writes for every accepted in-range convert coefficient, and
// compares each accepted write field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module weight_pair_checker #(
    parameter int SPIN_COUNT = iwq_pkg::SPIN_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_mode,
    input  logic [5:0]         i_row,
    input  logic [5:0]         i_col,
    input  logic signed [31:0] i_coef,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [6:0]         i_out_row,
    input  logic [6:0]         i_out_col,
    input  logic signed [4:0]  i_out_weight,
    input  logic               i_out_last,
    output int                 o_err_count,
    output int                 o_backlog
);
    import iwq_pkg::*;

    localparam int ONE_Q12 = 4096;

    typedef struct packed {
        logic [6:0]        row;
        logic [6:0]        col;
        logic signed [4:0] weight;
        logic              last;
    } t_write_cmd;

    t_write_cmd due_writes[$];

    logic [1:0]         norm_sel  = NM_LINEAR;
    logic [15:0]        scale_q12 = 16'(ONE_Q12);
    logic signed [31:0] lo_seen   = '0;
    logic signed [31:0] hi_seen   = '0;

    function automatic int quantize_weight(logic signed [31:0] coef);
        longint          prod;
        longint          span;
        longint          excess;
        longint unsigned mag;
        longint unsigned emag;
        longint unsigned den;
        longint unsigned q;
        prod = longint'({48'd0, scale_q12}) * longint'(coef);
        mag  = (prod < 0) ? -prod : prod;
        if (norm_sel == NM_DIRECT) begin
            q = (mag + (64'd1 << 27)) >> 28;
            if (q > WEIGHT_TOP) q = WEIGHT_TOP;
            return (prod < 0) ? -int'(q) : int'(q);
        end
        if (norm_sel == NM_SIGMOID) begin
            den = (64'd1 << 28) + mag;
            q   = (2 * WEIGHT_TOP * mag + den) / (2 * den);
            return (prod < 0) ? -int'(q) : int'(q);
        end
        span   = longint'(hi_seen) - longint'(lo_seen);
        excess = 2 * longint'(coef) - longint'(lo_seen) - longint'(hi_seen);
        if (span <= 0) return 0;
        emag = (excess < 0) ? -excess : excess;
        q    = (2 * WEIGHT_TOP * scale_q12 * emag + ONE_Q12 * span) / (2 * ONE_Q12 * span);
        if (q > WEIGHT_TOP) q = WEIGHT_TOP;
        return (excess < 0) ? -int'(q) : int'(q);
    endfunction

    function automatic void queue_write(logic [6:0] row, logic [6:0] col, int w, logic lst);
        t_write_cmd cmd;
        cmd.row    = row;
        cmd.col    = col;
        cmd.weight = 5'(w);
        cmd.last   = lst;
        due_writes.push_back(cmd);
    endfunction

    function automatic void absorb_coefficient(logic [1:0] md, logic [5:0] row,
                                               logic [5:0] col, logic signed [31:0] coef);
        int         w;
        int         half;
        int         rest;
        logic [6:0] r1;
        logic [6:0] c1;
        r1 = {1'b0, row} + 7'd1;
        c1 = {1'b0, col} + 7'd1;
        if (md == MD_CLEAR) begin
            lo_seen = '0;
            hi_seen = '0;
        end else if ((md == MD_SCAN || md == MD_CONVERT) && col >= row
                     && row < SPIN_COUNT && col < SPIN_COUNT) begin
            if (md == MD_SCAN) begin
                if (coef < lo_seen) lo_seen = coef;
                if (coef > hi_seen) hi_seen = coef;
            end else if (coef == 0) begin
                queue_write(r1, c1, 0, 1'b0);
                queue_write(c1, r1, 0, 1'b1);
            end else begin
                w    = quantize_weight(coef);
                half = w / 2;
                rest = half + w % 2;
                if (row == col) begin
                    queue_write(7'd0, c1, half, 1'b0);
                    queue_write(r1, 7'd0, rest, 1'b1);
                end else begin
                    queue_write(r1, c1, half, 1'b0);
                    queue_write(c1, r1, rest, 1'b1);
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_write_cmd want;
        if (!i_rst_n) begin
            norm_sel  = NM_LINEAR;
            scale_q12 = 16'(ONE_Q12);
            lo_seen   = '0;
            hi_seen   = '0;
            due_writes.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (due_writes.size() == 0) begin
                    $error("unexpected matrix write: row %0d, col %0d, weight %0d",
                           i_out_row, i_out_col, i_out_weight);
                    o_err_count++;
                end else begin
                    want = due_writes.pop_front();
                    if (i_out_row !== want.row) begin
                        $error("out_row: expected %0d, got %0d", want.row, i_out_row);
                        o_err_count++;
                    end
                    if (i_out_col !== want.col) begin
                        $error("out_col: expected %0d, got %0d", want.col, i_out_col);
                        o_err_count++;
                    end
                    if (i_out_weight !== want.weight) begin
                        $error("weight: expected %0d, got %0d", want.weight, i_out_weight);
                        o_err_count++;
                    end
                    if (i_out_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, i_out_last);
                        o_err_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_NORM_MODE) norm_sel = i_cfg_wdata[1:0];
                else scale_q12 = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready) begin
                absorb_coefficient(i_mode, i_row, i_col, i_coef);
            end
        end
        o_backlog = due_writes.size();
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ising weight quantizer testbench
// Drives coefficient transactions and register writes into the quantizer:
// a directed set covering each weight mode and corner case, then random
// clear, scan, convert and spare-mode sequences under changing mode and scale settings,
// with random idle cycles on both channels and one long output stall.
// ----------------------------------------------------------------------------
module testbench;
    import iwq_pkg::*;

    localparam int         ITEM_TARGET    = 750;
    localparam int         LATENCY_PAD    = 24;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         CROWD_CYCLES   = 300;
    localparam logic [1:0] NM_SPARE       = 2'd3;
    localparam logic [1:0] MD_SPARE       = 2'd3;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic               i_cfg_addr    = 1'b0;
    logic [15:0]        i_cfg_wdata   = '0;
    logic               i_valid       = 1'b0;
    logic               o_ready;
    logic [1:0]         i_mode        = MD_CLEAR;
    logic [5:0]         i_row_index   = '0;
    logic [5:0]         i_col_index   = '0;
    logic signed [31:0] i_coefficient = '0;
    logic               o_valid;
    logic               i_ready       = 1'b0;
    logic [6:0]         o_out_row;
    logic [6:0]         o_out_col;
    logic signed [4:0]  o_weight;
    logic               o_last;

    int err_count;
    int backlog;
    int counted     = 0;
    int idle_cycles = 0;
    int hold_left   = 0;
    bit steady      = 1'b0;
    bit crowd_req   = 1'b0;
    bit crowd_done  = 1'b0;

    ising_weight_quantizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_row_index   (i_row_index),
        .i_col_index   (i_col_index),
        .i_coefficient (i_coefficient),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_weight      (o_weight),
        .o_last        (o_last)
    );

    weight_pair_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_mode       (i_mode),
        .i_row        (i_row_index),
        .i_col        (i_col_index),
        .i_coef       (i_coefficient),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_row    (o_out_row),
        .i_out_col    (o_out_col),
        .i_out_weight (o_weight),
        .i_out_last   (o_last),
        .o_err_count  (err_count),
        .o_backlog    (backlog)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        int draw;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (crowd_req && !crowd_done) begin
            i_ready    <= 1'b0;
            hold_left  <= CROWD_CYCLES;
            crowd_done <= 1'b1;
        end else if (steady) begin
            i_ready <= 1'b1;
        end else begin
            draw = $urandom_range(0, 99);
            if (draw < 60) begin
                i_ready <= 1'b1;
            end else if (draw < 92) begin
                i_ready   <= 1'b0;
                hold_left <= $urandom_range(0, 3);
            end else begin
                i_ready   <= 1'b0;
                hold_left <= $urandom_range(8, 40);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        int draw;
        if (steady) return 0;
        draw = $urandom_range(0, 99);
        if (draw < 55) return 0;
        if (draw < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] draw_coef();
        int          draw;
        int          k;
        logic [31:0] mask;
        draw = $urandom_range(0, 9);
        if (draw == 0) return '0;
        if (draw == 1) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        if (draw < 4) return $urandom;
        k    = $urandom_range(4, 30);
        mask = (32'd1 << (k + 1)) - 32'd1;
        return ($urandom & mask) - (32'd1 << k);
    endfunction

    task automatic offer_item(input logic [1:0] md, input logic [5:0] row,
                              input logic [5:0] col, input logic [31:0] coef);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_mode        <= md;
        i_row_index   <= row;
        i_col_index   <= col;
        i_coefficient <= coef;
        do @(posedge i_clk); while (!o_ready);
        counted++;
    endtask

    task automatic offer_upper(input logic [1:0] md);
        logic [5:0] a;
        logic [5:0] b;
        a = 6'($urandom_range(0, 63));
        b = ($urandom_range(0, 9) == 0) ? a : 6'($urandom_range(0, 63));
        offer_item(md, (a < b) ? a : b, (a < b) ? b : a, draw_coef());
    endtask

    task automatic drain_and_wait();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (backlog != 0);
        repeat (LATENCY_PAD) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [1:0] norm, input logic [15:0] scale);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_NORM_MODE;
        i_cfg_wdata <= {14'd0, norm};
        @(posedge i_clk);
        i_cfg_addr  <= REG_SCALE;
        i_cfg_wdata <= scale;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int         phase;
        int         nconv;
        int         draw;
        logic [1:0] norm;
        logic [15:0] scale;
        logic [5:0] r;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: linear mode at unit scale, empty range first.
        offer_item(MD_CONVERT, 6'd0,  6'd1,  32'h0005_0000);
        offer_item(MD_SCAN,    6'd0,  6'd5,  32'h000A_0000);
        offer_item(MD_SCAN,    6'd1,  6'd2,  32'hFFFA_0000);
        offer_item(MD_SCAN,    6'd5,  6'd1,  32'h7FFF_FFFF);
        offer_item(MD_SPARE,   6'd2,  6'd7,  32'h8000_0000);
        offer_item(MD_CONVERT, 6'd0,  6'd5,  32'h000A_0000);
        offer_item(MD_CONVERT, 6'd1,  6'd2,  32'hFFFA_0000);
        offer_item(MD_CONVERT, 6'd3,  6'd3,  32'h0002_0000);
        offer_item(MD_CONVERT, 6'd0,  6'd0,  32'h0000_0000);
        offer_item(MD_CONVERT, 6'd63, 6'd63, 32'h7FFF_FFFF);
        offer_item(MD_CONVERT, 6'd0,  6'd63, 32'h8000_0000);
        offer_item(MD_CONVERT, 6'd10, 6'd3,  32'h0001_0000);
        offer_item(MD_CLEAR,   6'd0,  6'd0,  32'h0000_0000);
        offer_item(MD_CONVERT, 6'd2,  6'd4,  32'h0003_0000);
        drain_and_wait();

        program_regs(NM_DIRECT, 16'd4096);
        offer_item(MD_CONVERT, 6'd4,  6'd9,  32'h0000_8000);
        offer_item(MD_CONVERT, 6'd4,  6'd9,  32'hFFFF_8000);
        offer_item(MD_CONVERT, 6'd7,  6'd8,  32'h7FFF_FFFF);
        offer_item(MD_CONVERT, 6'd7,  6'd8,  32'h8000_0000);
        drain_and_wait();

        program_regs(NM_DIRECT, 16'hFFFF);
        offer_item(MD_CONVERT, 6'd62, 6'd63, 32'h0000_0001);
        offer_item(MD_CONVERT, 6'd2,  6'd2,  32'hFFFD_0000);
        drain_and_wait();

        program_regs(NM_SIGMOID, 16'd0);
        offer_item(MD_CONVERT, 6'd5,  6'd6,  32'h1234_5678);
        drain_and_wait();

        program_regs(NM_SIGMOID, 16'd4096);
        offer_item(MD_CONVERT, 6'd5,  6'd6,  32'h0001_0000);
        offer_item(MD_CONVERT, 6'd6,  6'd6,  32'hFFFF_0000);
        offer_item(MD_CONVERT, 6'd0,  6'd1,  32'h7FFF_FFFF);
        drain_and_wait();

        program_regs(NM_SPARE, 16'hFFFF);
        offer_item(MD_SCAN,    6'd0,  6'd1,  32'h0010_0000);
        offer_item(MD_CONVERT, 6'd0,  6'd1,  32'hFFF0_0000);
        drain_and_wait();

        phase = 0;
        while (counted < ITEM_TARGET) begin
            norm = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
            case ($urandom_range(0, 4))
                0:       scale = 16'd0;
                1:       scale = 16'hFFFF;
                2:       scale = 16'd4096;
                default: scale = 16'($urandom_range(0, 65535));
            endcase
            steady = (phase == 2) || (phase == 5);
            program_regs(norm, scale);
            offer_item(MD_CLEAR, 6'($urandom), 6'($urandom), $urandom);
            repeat ($urandom_range(3, 20)) offer_upper(MD_SCAN);
            if (phase == 2) crowd_req = 1'b1;
            nconv = $urandom_range(40, 90);
            repeat (nconv) begin
                draw = $urandom_range(0, 99);
                if (draw < 85) begin
                    offer_upper(MD_CONVERT);
                end else if (draw < 90) begin
                    offer_upper(MD_SCAN);
                end else if (draw < 92) begin
                    offer_item(MD_CLEAR, 6'($urandom), 6'($urandom), $urandom);
                end else if (draw < 96) begin
                    r = 6'($urandom_range(1, 63));
                    offer_item($urandom_range(0, 1) ? MD_SCAN : MD_CONVERT, r,
                               6'($urandom_range(0, r - 1)), draw_coef());
                end else begin
                    offer_item(MD_SPARE, 6'($urandom), 6'($urandom), $urandom);
                end
            end
            drain_and_wait();
            phase++;
        end

        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
